// ===== rtl/gpic_pkg.sv =====
// ----------------------------------------------------------------------------
// GPIO port interrupt controller package
// Shared types, codes, source map and helper functions.
// ----------------------------------------------------------------------------
package gpic_pkg;

    localparam int DEF_PORTS = 4;
    localparam int N_SRC     = 12;
    localparam int N_IRQ_BYTES = 6;

    localparam logic [7:0] DIR_RESET = 8'hff;
    localparam logic [7:0] IN_RESET  = 8'h02;

    // item codes
    localparam logic [2:0] FN_GPIO_RD  = 3'd0;
    localparam logic [2:0] FN_GPIO_WR  = 3'd1;
    localparam logic [2:0] FN_OUTER_RD = 3'd2;
    localparam logic [2:0] FN_OUTER_WR = 3'd3;
    localparam logic [2:0] FN_PIN      = 3'd4;

    // gpio register codes
    localparam logic [2:0] REG_SET  = 3'd0;
    localparam logic [2:0] REG_CLR  = 3'd1;
    localparam logic [2:0] REG_DIR  = 3'd2;
    localparam logic [2:0] REG_SFN  = 3'd3;
    localparam logic [2:0] REG_IRQ  = 3'd4;
    localparam logic [2:0] REG_LOAD = 3'd5;

    // outer interrupt register codes
    localparam logic [1:0] OREG_EXT   = 2'd0;
    localparam logic [1:0] OREG_P0_LO = 2'd1;
    localparam logic [1:0] OREG_P0_HI = 2'd2;
    localparam logic [1:0] OREG_P1    = 2'd3;

    localparam logic [7:0] MASK_ALL   = 8'hff;
    localparam logic [7:0] MASK_P0_LO = 8'h30;
    localparam logic [7:0] MASK_P0_HI = 8'hc0;
    localparam logic [7:0] MASK_P1    = 8'h41;

    // interrupt modes
    localparam logic [1:0] MODE_HIGH = 2'd0;
    localparam logic [1:0] MODE_LOW  = 2'd1;
    localparam logic [1:0] MODE_RISE = 2'd2;
    localparam logic [1:0] MODE_FALL = 2'd3;

    // source map: port and line feeding each source
    localparam logic [N_SRC-1:0] SRC_IS_EXT = 12'b0000_0011_0000;
    localparam logic [1:0] SRC_PORT [N_SRC] = '{
        2'd0, 2'd0, 2'd1, 2'd1, 2'd0, 2'd0,
        2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd1
    };
    localparam logic [2:0] SRC_LINE [N_SRC] = '{
        3'd2, 3'd3, 3'd2, 3'd3, 3'd0, 3'd0,
        3'd4, 3'd5, 3'd6, 3'd7, 3'd6, 3'd0
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
    } t_cmd;

    function automatic logic [7:0] irq_write(input logic [7:0] old_b, input logic [7:0] v);
        irq_write = {v[7:2], old_b[1:0] & ~v[1:0]};
    endfunction

    function automatic logic src_level(input logic [7:0] ctl, input logic b,
                                       input logic old_lv, input logic new_lv);
        logic       en;
        logic [1:0] mode;
        en   = b ? ctl[3] : ctl[2];
        mode = b ? ctl[7:6] : ctl[5:4];
        src_level = 1'b0;
        if (en) begin
            case (mode)
                MODE_HIGH: src_level = new_lv;
                MODE_LOW:  src_level = !new_lv;
                MODE_RISE: src_level = !old_lv && new_lv;
                default:   src_level = old_lv && !new_lv;
            endcase
        end
    endfunction

endpackage

// ===== rtl/gpic_ctrl.sv =====
// ----------------------------------------------------------------------------
// GPIO port interrupt controller sequencer
// Accepts a word, runs the execute state, holds the result until taken.
// ----------------------------------------------------------------------------
module gpic_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    output logic            o_valid,
    input  logic            i_stall,
    output gpic_pkg::t_cmd  o_cmd
);

    gpic_pkg::t_state r_state;
    gpic_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gpic_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_stall    = 1'b1;
        o_valid    = 1'b0;
        unique case (r_state)
            gpic_pkg::ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = gpic_pkg::ST_EXEC;
                end
            end
            gpic_pkg::ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = gpic_pkg::ST_OUT;
            end
            gpic_pkg::ST_OUT: begin
                o_valid = 1'b1;
                if (!i_stall) begin
                    n_state = gpic_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = gpic_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_no_accept_while_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("word accepted while a result is held");
    a_accept_runs_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (o_cmd.exec && !o_valid))
        else $error("accepted word not executed");
    a_exec_presents: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |=> o_valid)
        else $error("executed word not presented");
`endif

endmodule

// ===== rtl/gpic_dp.sv =====
// ----------------------------------------------------------------------------
// GPIO port interrupt controller datapath
// Port registers, interrupt bytes, source levels and drive levels.
// ----------------------------------------------------------------------------
module gpic_dp #(
    parameter int PORTS = gpic_pkg::DEF_PORTS
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  gpic_pkg::t_cmd  i_cmd,
    input  logic [2:0]      i_func,
    input  logic [4:0]      i_addr,
    input  logic [7:0]      i_wdata,
    input  logic [5:0]      i_pin,
    input  logic            i_level,
    output logic [7:0]      o_rdata,
    output logic [11:0]     o_irq_levels,
    output logic [31:0]     o_pin_drive
);

    localparam int PW = (PORTS > 2) ? 2 : 1;
    localparam int NB = gpic_pkg::N_IRQ_BYTES;
    localparam int NS = gpic_pkg::N_SRC;

    logic [2:0]  r_func;
    logic [4:0]  r_addr;
    logic [7:0]  r_wdata;
    logic [5:0]  r_pin;
    logic        r_level;
    logic [7:0]  r_rdata;

    logic [7:0]  r_dir   [PORTS];
    logic [7:0]  r_in    [PORTS];
    logic [7:0]  r_latch [PORTS];
    logic [7:0]  r_sf    [PORTS];
    logic [7:0]  r_irq   [NB];
    logic [1:0]  r_ext;
    logic [11:0] r_src;
    logic [31:0] r_drive;

    logic        is_grd, is_gwr, is_ord, is_owr, is_pin;
    logic        outer_ok, pin_ext, pin_port;
    logic [1:0]  sel;
    logic        in_rng;
    logic [PW-1:0] idx;
    logic [2:0]  reg_sel;
    logic [2:0]  obyte;
    logic [7:0]  cur_dir, cur_in, cur_latch, cur_sf;
    logic [7:0]  n_dir, n_in, n_latch, n_sf;
    logic [7:0]  eval_mask;
    logic [7:0]  irq_wr [NB];
    logic [7:0]  n_irq  [NB];
    logic [11:0] n_src;
    logic [1:0]  n_ext;
    logic [31:0] n_drive;
    logic [7:0]  n_rdata;
    logic [7:0]  drv_old, drv_new;
    logic        s_upd, s_old, s_new, s_lvl, s_hit;
    logic [2:0]  s_ln;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func  <= i_func;
            r_addr  <= i_addr;
            r_wdata <= i_wdata;
            r_pin   <= i_pin;
            r_level <= i_level;
        end
        if (i_cmd.exec) begin
            r_rdata <= n_rdata;
        end
    end

    always_comb begin
        is_grd   = (r_func == gpic_pkg::FN_GPIO_RD);
        is_gwr   = (r_func == gpic_pkg::FN_GPIO_WR);
        is_ord   = (r_func == gpic_pkg::FN_OUTER_RD);
        is_owr   = (r_func == gpic_pkg::FN_OUTER_WR);
        is_pin   = (r_func == gpic_pkg::FN_PIN);
        outer_ok = (r_addr[4:2] == 3'd0);
        pin_ext  = (r_pin[5:1] == 5'b10000);
        pin_port = !r_pin[5];
        reg_sel  = r_addr[2:0];
        obyte    = {1'b0, r_addr[1:0]} + 3'd2;

        if (is_pin) begin
            sel = r_pin[4:3];
        end else if (is_owr) begin
            sel = (r_addr[1:0] == gpic_pkg::OREG_P1) ? 2'd1 : 2'd0;
        end else begin
            sel = r_addr[4:3];
        end
        in_rng = (int'(sel) < PORTS);
        idx    = sel[PW-1:0];

        cur_dir   = in_rng ? r_dir[idx]   : 8'd0;
        cur_in    = in_rng ? r_in[idx]    : 8'd0;
        cur_latch = in_rng ? r_latch[idx] : 8'd0;
        cur_sf    = in_rng ? r_sf[idx]    : 8'd0;

        n_dir   = cur_dir;
        n_in    = cur_in;
        n_latch = cur_latch;
        n_sf    = cur_sf;
        for (int k = 0; k < NB; k++) begin
            irq_wr[k] = r_irq[k];
        end

        if (is_gwr && in_rng) begin
            unique case (reg_sel)
                gpic_pkg::REG_SET:  n_latch = cur_latch | r_wdata;
                gpic_pkg::REG_CLR:  n_latch = cur_latch & ~r_wdata;
                gpic_pkg::REG_LOAD: n_latch = r_wdata;
                gpic_pkg::REG_DIR:  n_dir   = cur_dir | r_wdata;
                gpic_pkg::REG_SFN:  n_sf    = r_wdata;
                gpic_pkg::REG_IRQ: begin
                    if (!sel[1]) begin
                        irq_wr[{2'b00, sel[0]}] =
                            gpic_pkg::irq_write(r_irq[{2'b00, sel[0]}], r_wdata);
                    end
                end
                default: ;
            endcase
        end
        if (is_owr && outer_ok) begin
            irq_wr[obyte] = gpic_pkg::irq_write(r_irq[obyte], r_wdata);
        end
        if (is_pin && pin_port) begin
            n_in[r_pin[2:0]] = r_level;
        end

        eval_mask = 8'd0;
        if (is_gwr && in_rng) begin
            eval_mask = gpic_pkg::MASK_ALL;
        end else if (is_owr && outer_ok) begin
            unique case (r_addr[1:0])
                gpic_pkg::OREG_P0_LO: eval_mask = gpic_pkg::MASK_P0_LO;
                gpic_pkg::OREG_P0_HI: eval_mask = gpic_pkg::MASK_P0_HI;
                gpic_pkg::OREG_P1:    eval_mask = gpic_pkg::MASK_P1;
                default:              eval_mask = 8'd0;
            endcase
        end

        for (int k = 0; k < NB; k++) begin
            n_irq[k] = irq_wr[k];
        end
        n_src = r_src;
        s_upd = 1'b0;
        s_old = 1'b0;
        s_new = 1'b0;
        s_lvl = 1'b0;
        s_hit = 1'b0;
        s_ln  = 3'd0;
        for (int n = 0; n < NS; n++) begin
            s_ln  = gpic_pkg::SRC_LINE[n];
            s_hit = in_rng && (sel == gpic_pkg::SRC_PORT[n]);
            if (gpic_pkg::SRC_IS_EXT[n]) begin
                s_upd = (is_owr && outer_ok && (r_addr[1:0] == gpic_pkg::OREG_EXT))
                     || (is_pin && pin_ext && (r_pin[0] == n[0]));
                s_old = r_ext[n[0]];
                s_new = is_pin ? r_level : r_ext[n[0]];
            end else begin
                s_upd = s_hit && ((eval_mask[s_ln] && n_sf[s_ln])
                     || (is_pin && pin_port && (r_pin[2:0] == s_ln)));
                s_old = is_pin ? (cur_in[s_ln] & cur_dir[s_ln]) : cur_in[s_ln];
                s_new = is_pin ? r_level : cur_in[s_ln];
            end
            s_lvl = gpic_pkg::src_level(irq_wr[n >> 1], n[0], s_old, s_new);
            if (s_upd) begin
                n_src[n]             = s_lvl;
                n_irq[n >> 1][n[0]]  = s_lvl;
            end
        end

        n_ext = r_ext;
        if (is_pin && pin_ext) begin
            n_ext[r_pin[0]] = r_level;
        end

        drv_old = r_drive[{sel, 3'b000} +: 8];
        for (int l = 0; l < 8; l++) begin
            drv_new[l] = (eval_mask[l] && !n_sf[l] && n_dir[l]) ? n_latch[l] : drv_old[l];
        end
        n_drive = r_drive;
        if (in_rng) begin
            n_drive[{sel, 3'b000} +: 8] = drv_new;
        end

        n_rdata = 8'd0;
        if (is_grd && in_rng) begin
            unique case (reg_sel)
                gpic_pkg::REG_SET:  n_rdata = cur_in & cur_dir;
                gpic_pkg::REG_CLR:  n_rdata = cur_latch;
                gpic_pkg::REG_DIR:  n_rdata = cur_dir;
                gpic_pkg::REG_SFN:  n_rdata = cur_sf;
                gpic_pkg::REG_IRQ:  n_rdata = sel[1] ? 8'd0 : r_irq[{2'b00, sel[0]}];
                default:            n_rdata = 8'd0;
            endcase
        end else if (is_ord && outer_ok) begin
            n_rdata = r_irq[obyte];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < PORTS; p++) begin
                r_dir[p]   <= gpic_pkg::DIR_RESET;
                r_in[p]    <= gpic_pkg::IN_RESET;
                r_latch[p] <= 8'd0;
                r_sf[p]    <= 8'd0;
            end
            for (int k = 0; k < NB; k++) begin
                r_irq[k] <= 8'd0;
            end
            r_ext   <= 2'd0;
            r_src   <= 12'd0;
            r_drive <= 32'd0;
        end else if (i_cmd.exec) begin
            if (in_rng) begin
                r_dir[idx]   <= n_dir;
                r_in[idx]    <= n_in;
                r_latch[idx] <= n_latch;
                r_sf[idx]    <= n_sf;
            end
            for (int k = 0; k < NB; k++) begin
                r_irq[k] <= n_irq[k];
            end
            r_ext   <= n_ext;
            r_src   <= n_src;
            r_drive <= n_drive;
        end
    end

    assign o_rdata      = r_rdata;
    assign o_irq_levels = r_src;
    assign o_pin_drive  = r_drive;

`ifndef SYNTHESIS
    a_drive_unused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_drive >> (PORTS * 8)) == 32'd0))
        else $error("drive level set beyond the last port");
    a_read_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && (is_grd || is_ord))
        |=> ($stable(r_src) && $stable(r_drive) && $stable(r_ext)))
        else $error("read word changed state");
    a_pin_keeps_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && is_pin) |=> $stable(r_drive))
        else $error("pin change altered drive levels");
`endif

endmodule

// ===== rtl/gpio_port_interrupt_controller.sv =====
// An accepted word passes the execute state, then the present state, where the
// result can be taken; the next word is accepted the cycle after the result is taken.
// The result stays on the outputs while o_valid is high and i_stall is high.
// Reset (synchronous, active low) restores all port, interrupt and drive
// registers to their defaults.
// ----------------------------------------------------------------------------
// GPIO port interrupt controller
// Four-port GPIO with a twelve-source interrupt unit, one result per word.
// ----------------------------------------------------------------------------
module gpio_port_interrupt_controller #(
    parameter int PORTS = gpic_pkg::DEF_PORTS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_func,
    input  logic [4:0]  i_addr,
    input  logic [7:0]  i_wdata,
    input  logic [5:0]  i_pin,
    input  logic        i_level,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_rdata,
    output logic [11:0] o_irq_levels,
    output logic [31:0] o_pin_drive
);

    gpic_pkg::t_cmd cmd;

    gpic_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (cmd)
    );

    gpic_dp #(
        .PORTS (PORTS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_func       (i_func),
        .i_addr       (i_addr),
        .i_wdata      (i_wdata),
        .i_pin        (i_pin),
        .i_level      (i_level),
        .o_rdata      (o_rdata),
        .o_irq_levels (o_irq_levels),
        .o_pin_drive  (o_pin_drive)
    );

endmodule

// ===== tb/sv/gpio_port_interrupt_controller_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// GPIO port interrupt controller testbench
// Sends directed and random register accesses and pin changes through the
// valid/stall input channel, with bursty sending and patterned output stalls.
// Every result word is checked against an in-bench model of the port, drive
// and interrupt state.
// ----------------------------------------------------------------------------
module gpio_port_interrupt_controller_tb;

    localparam int NPORT       = gpic_pkg::DEF_PORTS;
    localparam int NO_SOURCE   = 15;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 200;
    localparam int HOLD_AT     = 400;
    localparam int RANDOM_HALF = 650;

    typedef struct packed {
        logic [2:0] func;
        logic [4:0] addr;
        logic [7:0] wdata;
        logic [5:0] pin;
        logic       level;
    } t_gpio_word;

    typedef struct packed {
        logic [7:0]  rdata;
        logic [11:0] irq;
        logic [31:0] drive;
    } t_gpio_result;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [2:0]  i_func  = '0;
    logic [4:0]  i_addr  = '0;
    logic [7:0]  i_wdata = '0;
    logic [5:0]  i_pin   = '0;
    logic        i_level = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [7:0]  o_rdata;
    logic [11:0] o_irq_levels;
    logic [31:0] o_pin_drive;

    gpio_port_interrupt_controller #(
        .PORTS(NPORT)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_func       (i_func),
        .i_addr       (i_addr),
        .i_wdata      (i_wdata),
        .i_pin        (i_pin),
        .i_level      (i_level),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_rdata      (o_rdata),
        .o_irq_levels (o_irq_levels),
        .o_pin_drive  (o_pin_drive)
    );

    // model state
    logic [7:0]  dir_m   [NPORT];
    logic [7:0]  in_m    [NPORT];
    logic [7:0]  latch_m [NPORT];
    logic [7:0]  sfn_m   [NPORT];
    logic [7:0]  ctl_m   [6];
    logic [1:0]  ext_m;
    logic [11:0] src_m;
    logic [31:0] drv_m;

    t_gpio_word   words_to_send [$];
    t_gpio_result due_results   [$];
    t_gpio_word   offered;

    int error_count = 0;
    int n_results   = 0;
    int n_words     = 0;
    int burst_left  = 1;
    int gap_left    = 0;
    int hold_left   = 0;
    bit hold_done   = 1'b0;
    int rx_mode     = 0;
    int mode_left   = 0;
    int rx_tick     = 0;
    logic send_nx;
    logic stall_nx;
    t_gpio_result got;
    t_gpio_result want;

    int unsigned mapped_pins [12] = '{2, 3, 4, 5, 6, 7, 8, 10, 11, 14, 32, 33};

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= 10) begin
            $display("%0t: %s", $time, msg);
        end
    endtask

    function automatic int source_for(input int port, input int line);
        int s;
        s = NO_SOURCE;
        if (port == 0) begin
            case (line)
                2: s = 0;
                3: s = 1;
                4: s = 6;
                5: s = 7;
                6: s = 8;
                7: s = 9;
                default: s = NO_SOURCE;
            endcase
        end else if (port == 1) begin
            case (line)
                0: s = 11;
                2: s = 2;
                3: s = 3;
                6: s = 10;
                default: s = NO_SOURCE;
            endcase
        end
        return s;
    endfunction

    function automatic void refresh_source(input int num, input logic old_lv,
                                           input logic new_lv);
        int         idx;
        int         b;
        logic [7:0] ctl;
        logic [1:0] md;
        logic       lvl;
        if (num > 11) return;
        idx = num / 2;
        b   = num % 2;
        ctl = ctl_m[idx];
        md  = ctl[4 + 2 * b +: 2];
        lvl = 1'b0;
        if (ctl[2 + b]) begin
            case (md)
                gpic_pkg::MODE_HIGH: lvl = new_lv;
                gpic_pkg::MODE_LOW:  lvl = !new_lv;
                gpic_pkg::MODE_RISE: lvl = !old_lv && new_lv;
                default:             lvl = old_lv && !new_lv;
            endcase
        end
        ctl_m[idx][b] = lvl;
        src_m[num]    = lvl;
    endfunction

    function automatic void settle_line(input int port, input int line);
        logic lv;
        if (port >= NPORT || line > 7) return;
        if (sfn_m[port][line]) begin
            lv = in_m[port][line];
            refresh_source(source_for(port, line), lv, lv);
        end else if (dir_m[port][line]) begin
            drv_m[port * 8 + line] = latch_m[port][line];
        end
    endfunction

    function automatic logic [7:0] ack_byte(input logic [7:0] old_b, input logic [7:0] v);
        return (old_b & 8'h03 & ~v) | (v & 8'hfc);
    endfunction

    function automatic t_gpio_result gpio_predict(input t_gpio_word w);
        t_gpio_result r;
        int           port;
        int           line;
        int           oidx;
        logic [2:0]   rg;
        logic         old_lv;
        port    = int'(w.addr[4:3]);
        rg      = w.addr[2:0];
        r.rdata = 8'h00;
        if (w.func == gpic_pkg::FN_GPIO_RD) begin
            if (port < NPORT) begin
                case (rg)
                    gpic_pkg::REG_SET: r.rdata = in_m[port] & dir_m[port];
                    gpic_pkg::REG_CLR: r.rdata = latch_m[port];
                    gpic_pkg::REG_DIR: r.rdata = dir_m[port];
                    gpic_pkg::REG_SFN: r.rdata = sfn_m[port];
                    gpic_pkg::REG_IRQ: r.rdata = (port < 2) ? ctl_m[port] : 8'h00;
                    default:           r.rdata = 8'h00;
                endcase
            end
        end else if (w.func == gpic_pkg::FN_GPIO_WR) begin
            if (port < NPORT) begin
                case (rg)
                    gpic_pkg::REG_SET:  latch_m[port] = latch_m[port] | w.wdata;
                    gpic_pkg::REG_CLR:  latch_m[port] = latch_m[port] & ~w.wdata;
                    gpic_pkg::REG_LOAD: latch_m[port] = w.wdata;
                    gpic_pkg::REG_DIR:  dir_m[port]   = dir_m[port] | w.wdata;
                    gpic_pkg::REG_SFN:  sfn_m[port]   = w.wdata;
                    gpic_pkg::REG_IRQ: begin
                        if (port < 2) begin
                            ctl_m[port] = ack_byte(ctl_m[port], w.wdata);
                            settle_line(port, 2);
                            settle_line(port, 3);
                        end
                    end
                    default: ;
                endcase
                for (line = 0; line < 8; line++) begin
                    settle_line(port, line);
                end
            end
        end else if (w.func == gpic_pkg::FN_OUTER_RD) begin
            if (w.addr < 5'd4) begin
                r.rdata = ctl_m[int'(w.addr) + 2];
            end
        end else if (w.func == gpic_pkg::FN_OUTER_WR) begin
            if (w.addr < 5'd4) begin
                oidx        = int'(w.addr) + 2;
                ctl_m[oidx] = ack_byte(ctl_m[oidx], w.wdata);
                case (w.addr[1:0])
                    gpic_pkg::OREG_EXT: begin
                        refresh_source(4, ext_m[0], ext_m[0]);
                        refresh_source(5, ext_m[1], ext_m[1]);
                    end
                    gpic_pkg::OREG_P0_LO: begin
                        settle_line(0, 4);
                        settle_line(0, 5);
                    end
                    gpic_pkg::OREG_P0_HI: begin
                        settle_line(0, 6);
                        settle_line(0, 7);
                    end
                    default: begin
                        settle_line(1, 6);
                        settle_line(1, 0);
                    end
                endcase
            end
        end else if (w.func == gpic_pkg::FN_PIN) begin
            if (w.pin == 6'd32 || w.pin == 6'd33) begin
                line = int'(w.pin) - 32;
                refresh_source(4 + line, ext_m[line], w.level);
                ext_m[line] = w.level;
            end else if (w.pin < 6'd32) begin
                port = int'(w.pin[4:3]);
                line = int'(w.pin[2:0]);
                if (port < NPORT) begin
                    old_lv           = in_m[port][line] & dir_m[port][line];
                    in_m[port][line] = w.level;
                    refresh_source(source_for(port, line), old_lv, w.level);
                end
            end
        end
        r.irq   = src_m;
        r.drive = drv_m;
        return r;
    endfunction

    function automatic t_gpio_word make_word(input logic [2:0] func, input logic [4:0] addr,
                                             input logic [7:0] wdata, input logic [5:0] pin,
                                             input logic level);
        t_gpio_word w;
        w.func  = func;
        w.addr  = addr;
        w.wdata = wdata;
        w.pin   = pin;
        w.level = level;
        return w;
    endfunction

    function automatic void queue_word(input t_gpio_word w);
        words_to_send.push_back(w);
        n_words++;
    endfunction

    function automatic t_gpio_word pick_word();
        t_gpio_word w;
        int         roll;
        w.func  = gpic_pkg::FN_GPIO_RD;
        w.addr  = 5'($urandom_range(0, 31));
        w.wdata = 8'($urandom_range(0, 255));
        w.pin   = 6'($urandom_range(0, 63));
        w.level = 1'($urandom_range(0, 1));
        roll    = $urandom_range(0, 99);
        if (roll < 30) begin
            w.func = gpic_pkg::FN_PIN;
            w.pin  = 6'(mapped_pins[$urandom_range(0, 11)]);
        end else if (roll < 38) begin
            w.func = gpic_pkg::FN_PIN;
        end else if (roll < 52) begin
            w.func = gpic_pkg::FN_GPIO_WR;
        end else if (roll < 62) begin
            if ($urandom_range(0, 1)) begin
                w.func = gpic_pkg::FN_GPIO_WR;
                w.addr = {1'b0, 1'($urandom_range(0, 1)), gpic_pkg::REG_IRQ};
            end else begin
                w.func = gpic_pkg::FN_OUTER_WR;
                w.addr = 5'($urandom_range(0, 3));
            end
        end else if (roll < 77) begin
            w.func = gpic_pkg::FN_GPIO_RD;
        end else if (roll < 85) begin
            w.func = gpic_pkg::FN_OUTER_RD;
            if ($urandom_range(0, 1)) w.addr = 5'($urandom_range(0, 3));
        end else if (roll < 93) begin
            w.func = gpic_pkg::FN_OUTER_WR;
        end else begin
            w.func = 3'($urandom_range(5, 7));
        end
        return w;
    endfunction

    task automatic wait_drained();
        while (n_results < n_words) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        int k;
        for (k = 0; k < NPORT; k++) begin
            dir_m[k]   = gpic_pkg::DIR_RESET;
            in_m[k]    = gpic_pkg::IN_RESET;
            latch_m[k] = 8'h00;
            sfn_m[k]   = 8'h00;
        end
        for (k = 0; k < 6; k++) begin
            ctl_m[k] = 8'h00;
        end
        ext_m = 2'b00;
        src_m = '0;
        drv_m = '0;
    end

    // sender: hold the word until taken, bursts separated by random idle gaps, possibly empty
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            send_nx = i_valid;
            if (i_valid && !o_stall) begin
                due_results.push_back(gpio_predict(offered));
                send_nx = 1'b0;
            end
            if (!send_nx) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (words_to_send.size() > 0) begin
                    offered = words_to_send.pop_front();
                    i_func  <= offered.func;
                    i_addr  <= offered.addr;
                    i_wdata <= offered.wdata;
                    i_pin   <= offered.pin;
                    i_level <= offered.level;
                    send_nx = 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
            i_valid <= send_nx;
        end
    end

    // receiver: check each result word, stall on a changing pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                got = '{o_rdata, o_irq_levels, o_pin_drive};
                if (due_results.size() == 0) begin
                    flag_error($sformatf("unexpected result word rdata=%02h irq=%03h drive=%08h",
                                         got.rdata, got.irq, got.drive));
                end else begin
                    want = due_results.pop_front();
                    if (got.rdata !== want.rdata) begin
                        flag_error($sformatf("rdata: expected %02h, got %02h",
                                             want.rdata, got.rdata));
                    end
                    if (got.irq !== want.irq) begin
                        flag_error($sformatf("irq_levels: expected %03h, got %03h",
                                             want.irq, got.irq));
                    end
                    if (got.drive !== want.drive) begin
                        flag_error($sformatf("pin_drive: expected %08h, got %08h",
                                             want.drive, got.drive));
                    end
                end
                n_results++;
            end
            rx_tick++;
            if (hold_left > 0) begin
                hold_left--;
                stall_nx = 1'b1;
            end else if (!hold_done && n_results >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                stall_nx  = 1'b1;
            end else begin
                if (mode_left == 0) begin
                    rx_mode   = $urandom_range(0, 2);
                    mode_left = $urandom_range(20, 80);
                end else begin
                    mode_left--;
                end
                case (rx_mode)
                    0:       stall_nx = 1'b0;
                    1:       stall_nx = ($urandom_range(0, 99) < 35);
                    default: stall_nx = ((rx_tick % 7) < 3);
                endcase
            end
            i_stall <= stall_nx;
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        int k;
        queue_word(make_word(gpic_pkg::FN_GPIO_RD, 5'd0, 8'h00, 6'd0, 1'b0));
        queue_word(make_word(gpic_pkg::FN_GPIO_WR, {2'd0, gpic_pkg::REG_IRQ}, 8'hff,
                             6'd63, 1'b1));
        queue_word(make_word(gpic_pkg::FN_PIN, 5'd31, 8'hff, 6'd2, 1'b1));
        queue_word(make_word(gpic_pkg::FN_PIN, 5'd0, 8'h00, 6'd2, 1'b0));
        queue_word(make_word(gpic_pkg::FN_OUTER_WR, {3'd0, gpic_pkg::OREG_EXT}, 8'h6c,
                             6'd0, 1'b0));
        queue_word(make_word(gpic_pkg::FN_PIN, 5'd0, 8'h00, 6'd32, 1'b1));
        queue_word(make_word(gpic_pkg::FN_PIN, 5'd0, 8'h00, 6'd33, 1'b0));
        queue_word(make_word(gpic_pkg::FN_GPIO_WR, {2'd3, gpic_pkg::REG_LOAD}, 8'hff,
                             6'd0, 1'b0));
        queue_word(make_word(gpic_pkg::FN_GPIO_WR, {2'd1, gpic_pkg::REG_SET}, 8'ha5,
                             6'd0, 1'b0));
        queue_word(make_word(gpic_pkg::FN_GPIO_WR, {2'd1, gpic_pkg::REG_CLR}, 8'hff,
                             6'd0, 1'b0));
        queue_word(make_word(gpic_pkg::FN_GPIO_WR, {2'd2, gpic_pkg::REG_DIR}, 8'h00,
                             6'd0, 1'b0));
        queue_word(make_word(gpic_pkg::FN_GPIO_WR, {2'd0, gpic_pkg::REG_SFN}, 8'hfc,
                             6'd0, 1'b0));
        queue_word(make_word(gpic_pkg::FN_GPIO_RD, {2'd0, gpic_pkg::REG_SFN}, 8'h00,
                             6'd0, 1'b0));
        queue_word(make_word(gpic_pkg::FN_GPIO_RD, {2'd1, gpic_pkg::REG_CLR}, 8'h00,
                             6'd0, 1'b0));
        queue_word(make_word(gpic_pkg::FN_GPIO_RD, {2'd2, gpic_pkg::REG_DIR}, 8'h00,
                             6'd0, 1'b0));
        queue_word(make_word(gpic_pkg::FN_GPIO_RD, {2'd0, gpic_pkg::REG_IRQ}, 8'h00,
                             6'd0, 1'b0));
        queue_word(make_word(gpic_pkg::FN_GPIO_WR, 5'd31, 8'hff, 6'd0, 1'b0));
        queue_word(make_word(gpic_pkg::FN_GPIO_RD, 5'd30, 8'h00, 6'd0, 1'b0));
        queue_word(make_word(gpic_pkg::FN_GPIO_WR, {2'd2, gpic_pkg::REG_IRQ}, 8'hff,
                             6'd0, 1'b0));
        queue_word(make_word(gpic_pkg::FN_GPIO_RD, {2'd3, gpic_pkg::REG_IRQ}, 8'h00,
                             6'd0, 1'b0));
        queue_word(make_word(gpic_pkg::FN_OUTER_RD, {3'd0, gpic_pkg::OREG_EXT}, 8'h00,
                             6'd0, 1'b0));
        queue_word(make_word(gpic_pkg::FN_OUTER_RD, 5'd31, 8'h00, 6'd0, 1'b0));
        queue_word(make_word(gpic_pkg::FN_OUTER_WR, 5'd17, 8'hff, 6'd0, 1'b0));
        queue_word(make_word(gpic_pkg::FN_PIN, 5'd0, 8'h00, 6'd63, 1'b1));
        queue_word(make_word(gpic_pkg::FN_PIN, 5'd0, 8'h00, 6'd34, 1'b0));
        queue_word(make_word(3'd7, 5'd31, 8'hff, 6'd63, 1'b1));
        queue_word(make_word(3'd5, 5'd0, 8'h00, 6'd0, 1'b0));
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait_drained();
        for (k = 0; k < RANDOM_HALF; k++) begin
            queue_word(pick_word());
        end
        wait_drained();
        for (k = 0; k < RANDOM_HALF; k++) begin
            queue_word(pick_word());
        end
        wait_drained();
        repeat (10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
